// ===== rtl/core/btffa_pkg.sv =====
`timescale 1ns / 1ps

package btffa_pkg;

   // Pool geometry
   localparam int unsigned POOL_BYTES   = 65536;
   localparam int unsigned ALIGN_BYTES  = 8;
   localparam int unsigned POOL_TOTAL_I =
      ((POOL_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int unsigned POOL_WORDS   = POOL_TOTAL_I / 4;
   localparam int unsigned WORD_AW      = $clog2(POOL_WORDS);
   localparam int unsigned OVERHEAD_I   = 12 + 4;
   localparam int unsigned WALK_LIMIT   = POOL_TOTAL_I / OVERHEAD_I + 1;
   localparam int unsigned WALK_W       = $clog2(WALK_LIMIT);

   localparam logic [31:0] POOL_TOTAL   = 32'(POOL_TOTAL_I);
   localparam logic [31:0] HDR_BYTES    = 32'd12;
   localparam logic [31:0] FTR_BYTES    = 32'd4;
   localparam logic [31:0] OVERHEAD     = 32'(OVERHEAD_I);
   localparam logic [31:0] ALIGN_MASK   = 32'(ALIGN_BYTES - 1);
   localparam logic [31:0] ALLOC_MARK   = 32'h8000_0000;
   localparam logic [31:0] SIZE_MASK    = 32'h7FFF_FFFF;
   localparam logic [31:0] INIT_SIZE    = POOL_TOTAL - OVERHEAD;
   localparam logic [31:0] LINK_PREV    = 32'd4;
   localparam logic [31:0] LINK_NEXT    = 32'd8;

   // Response codes
   localparam logic [1:0] RSP_GRANTED = 2'd0;
   localparam logic [1:0] RSP_NO_FIT  = 2'd1;
   localparam logic [1:0] RSP_FREED   = 2'd2;
   localparam logic [1:0] RSP_IGNORED = 2'd3;

   // Datapath micro-operations
   typedef enum logic [6:0] {
      OP_NOP,
      OP_CLEAR, OP_INIT_LO, OP_INIT_HI,
      OP_A_START, OP_A_TEST, OP_A_NEXT, OP_A_CHK,
      OP_S_FOOT, OP_S_NH, OP_S_RD, OP_S_NHNX, OP_S_NHPV, OP_S_NXPV, OP_S_HNX, OP_S_NFOOT,
      OP_U_RDNX, OP_U_RDPV, OP_U_HEAD, OP_U_PVNX, OP_U_NXPV, OP_U_HPV, OP_U_HNX,
      OP_U_HDR, OP_U_FTR,
      OP_F_START, OP_F_HDR, OP_F_WH, OP_F_WF, OP_F_RDPF, OP_F_LCHK,
      OP_F_LPH, OP_F_LF, OP_F_LPF, OP_F_LH0, OP_F_LH4, OP_F_LH8,
      OP_R_RDNH, OP_R_CHK, OP_R_RDNP, OP_R_RDNN, OP_R_WB, OP_R_WNF, OP_R_WF0,
      OP_R_L1, OP_R_L2, OP_R_S1, OP_R_S2, OP_R_M1, OP_R_M2, OP_R_M3, OP_R_M4,
      OP_R_TAIL, OP_R_Z4, OP_R_Z8,
      OP_N_E1, OP_N_E2, OP_N_RDT, OP_N_T1, OP_N_T2, OP_N_T3, OP_N_T4,
      OP_RES_GRANT, OP_RES_NOFIT, OP_RES_FREED, OP_RES_IGN
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load;
   } cmd_type;

   typedef struct packed {
      logic kind;
      logic bad_addr;
      logic empty;
      logic fit;
      logic next_is_head;
      logic walk_last;
      logic split;
      logic no_mark;
      logic bad_size;
      logic foot_mismatch;
      logic h_gt4;
      logic left_ok;
      logic right_room;
      logic right_ok;
      logic left;
      logic right;
      logic nn_is_nh;
      logic clr_last;
   } sts_type;

endpackage

// ===== rtl/core/btffa_ram.sv =====
`timescale 1ns / 1ps

module btffa_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/core/btffa_dpath.sv =====
`timescale 1ns / 1ps

module btffa_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_kind,
   input  logic [16:0]             req_request_size,
   input  logic [15:0]             req_block_address,
   input  btffa_pkg::cmd_type      cmd,
   output btffa_pkg::sts_type      sts,
   output logic [1:0]              rsp_status,
   output logic [15:0]             rsp_granted_address
);
   import btffa_pkg::*;

   logic [31:0] need_ff, need_in, cur_ff, cur_in, h_ff, h_in, size_ff, size_in;
   logic [31:0] foot_ff, foot_in, nx_ff, nx_in, pv_ff, pv_in, nh_ff, nh_in;
   logic [31:0] rest_ff, rest_in, m_ff, m_in, hv_ff, hv_in, b_ff, b_in;
   logic [31:0] head_ff, head_in;
   logic [15:0] addr_ff, addr_in;
   logic        kind_ff, kind_in;
   logic [WALK_W-1:0]  walk_ff, walk_in;
   logic [WORD_AW-1:0] clr_ff, clr_in;
   logic        empty_ff, empty_in, left_ff, left_in, right_ff, right_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] gaddr_ff, gaddr_in;

   logic               we;
   logic               use_clr;
   logic [31:0]        wbyte;
   logic [31:0]        wdata;
   logic [31:0]        rdata;
   logic [31:0]        rd_size;
   logic [31:0]        h_free;
   logic [WORD_AW-1:0] ram_addr;

   assign rd_size  = rdata & SIZE_MASK;
   assign h_free   = {16'd0, addr_ff} - HDR_BYTES;
   assign ram_addr = use_clr ? clr_ff : wbyte[WORD_AW+1:2];

   btffa_ram #(.WIDTH(32), .DEPTH(POOL_WORDS)) u_pool (
      .clock (clock),
      .we    (we),
      .addr  (ram_addr),
      .wdata (wdata),
      .rdata (rdata)
   );

   // status toward the controller
   always_comb begin
      sts.kind          = kind_ff;
      sts.bad_addr      = (addr_ff < HDR_BYTES[15:0]) || (addr_ff[1:0] != 2'd0);
      sts.empty         = empty_ff;
      sts.fit           = rd_size >= need_ff;
      sts.next_is_head  = rdata == head_ff;
      sts.walk_last     = walk_ff == WALK_W'(WALK_LIMIT - 1);
      sts.split         = (size_ff - need_ff) > OVERHEAD;
      sts.no_mark       = !rdata[31];
      sts.bad_size      = (rd_size > POOL_TOTAL) ||
                          (({1'b0, h_ff} + {1'b0, OVERHEAD} + {1'b0, rd_size}) >
                           {1'b0, POOL_TOTAL});
      sts.foot_mismatch = rdata != hv_ff;
      sts.h_gt4         = h_ff > FTR_BYTES;
      sts.left_ok       = !rdata[31] &&
                          (({1'b0, rdata} + {1'b0, OVERHEAD}) <= {1'b0, h_ff});
      sts.right_room    = ({1'b0, foot_ff} + 33'd8) < {1'b0, POOL_TOTAL};
      sts.right_ok      = !rdata[31] &&
                          (({1'b0, nh_ff} + {1'b0, OVERHEAD} + {1'b0, rdata}) <=
                           {1'b0, POOL_TOTAL});
      sts.left          = left_ff;
      sts.right         = right_ff;
      sts.nn_is_nh      = nx_ff == nh_ff;
      sts.clr_last      = &clr_ff;
   end

   // micro-operation decode
   always_comb begin
      need_in = need_ff;  cur_in = cur_ff;   h_in = h_ff;       size_in = size_ff;
      foot_in = foot_ff;  nx_in = nx_ff;     pv_in = pv_ff;     nh_in = nh_ff;
      rest_in = rest_ff;  m_in = m_ff;       hv_in = hv_ff;     b_in = b_ff;
      head_in = head_ff;  addr_in = addr_ff; kind_in = kind_ff; walk_in = walk_ff;
      clr_in = clr_ff;    empty_in = empty_ff;
      left_in = left_ff;  right_in = right_ff;
      status_in = status_ff; gaddr_in = gaddr_ff;
      we = 1'b0;  use_clr = 1'b0;  wbyte = h_ff;  wdata = 32'd0;

      if (cmd.load) begin
         kind_in = req_kind;
         addr_in = req_block_address;
         need_in = ({15'd0, req_request_size} + ALIGN_MASK) & ~ALIGN_MASK;
      end

      case (cmd.op)
         OP_CLEAR: begin
            we = 1'b1;  use_clr = 1'b1;  clr_in = clr_ff + 1'b1;
         end
         OP_INIT_LO: begin
            we = 1'b1;  wbyte = 32'd0;  wdata = INIT_SIZE;
         end
         OP_INIT_HI: begin
            we = 1'b1;  wbyte = HDR_BYTES + INIT_SIZE;  wdata = INIT_SIZE;
         end
         // first-fit walk
         OP_A_START: begin
            cur_in = head_ff;  walk_in = '0;  wbyte = head_ff;
         end
         OP_A_TEST: begin
            if (rd_size >= need_ff) begin
               h_in = cur_ff;  size_in = rd_size;
            end
            wbyte = cur_ff + LINK_NEXT;
         end
         OP_A_NEXT: begin
            cur_in = rdata;  walk_in = walk_ff + 1'b1;  wbyte = rdata;
         end
         OP_A_CHK: begin
            if ((size_ff - need_ff) > OVERHEAD) begin
               foot_in = h_ff + HDR_BYTES + need_ff;
               nh_in   = h_ff + OVERHEAD + need_ff;
               rest_in = size_ff - need_ff - OVERHEAD;
            end else begin
               foot_in = h_ff + HDR_BYTES + size_ff;
            end
         end
         // split
         OP_S_FOOT:  begin we = 1'b1; wbyte = foot_ff;           wdata = need_ff; end
         OP_S_NH:    begin we = 1'b1; wbyte = nh_ff;             wdata = rest_ff; end
         OP_S_RD:    begin wbyte = h_ff + LINK_NEXT; end
         OP_S_NHNX: begin
            nx_in = rdata;  we = 1'b1;  wbyte = nh_ff + LINK_NEXT;  wdata = rdata;
         end
         OP_S_NHPV:  begin we = 1'b1; wbyte = nh_ff + LINK_PREV; wdata = h_ff; end
         OP_S_NXPV:  begin we = 1'b1; wbyte = nx_ff + LINK_PREV; wdata = nh_ff; end
         OP_S_HNX:   begin we = 1'b1; wbyte = h_ff + LINK_NEXT;  wdata = nh_ff; end
         OP_S_NFOOT: begin
            we = 1'b1;  wbyte = nh_ff + HDR_BYTES + rest_ff;  wdata = rest_ff;
            size_in = need_ff;
         end
         // unlink and mark
         OP_U_RDNX:  begin wbyte = h_ff + LINK_NEXT; end
         OP_U_RDPV:  begin nx_in = rdata;  wbyte = h_ff + LINK_PREV; end
         OP_U_HEAD: begin
            pv_in = rdata;
            if (h_ff == head_ff) begin
               if (nx_ff != h_ff) head_in = nx_ff;
               else               empty_in = 1'b1;
            end
         end
         OP_U_PVNX:  begin we = 1'b1; wbyte = pv_ff + LINK_NEXT; wdata = nx_ff; end
         OP_U_NXPV:  begin we = 1'b1; wbyte = nx_ff + LINK_PREV; wdata = pv_ff; end
         OP_U_HPV:   begin we = 1'b1; wbyte = h_ff + LINK_PREV;  wdata = h_ff; end
         OP_U_HNX:   begin we = 1'b1; wbyte = h_ff + LINK_NEXT;  wdata = h_ff; end
         OP_U_HDR:   begin we = 1'b1; wbyte = h_ff;    wdata = size_ff | ALLOC_MARK; end
         OP_U_FTR:   begin we = 1'b1; wbyte = foot_ff; wdata = size_ff | ALLOC_MARK; end
         // free: validate
         OP_F_START: begin h_in = h_free;  wbyte = h_free; end
         OP_F_HDR: begin
            hv_in = rdata;  size_in = rd_size;
            foot_in = h_ff + HDR_BYTES + rd_size;
            wbyte = h_ff + HDR_BYTES + rd_size;
         end
         OP_F_WH: begin
            we = 1'b1;  wbyte = h_ff;  wdata = size_ff;
            b_in = h_ff;  left_in = 1'b0;  right_in = 1'b0;
         end
         OP_F_WF:    begin we = 1'b1; wbyte = foot_ff; wdata = size_ff; end
         // merge with left neighbor
         OP_F_RDPF:  begin wbyte = h_ff - FTR_BYTES; end
         OP_F_LCHK: begin
            if (!rdata[31] && (({1'b0, rdata} + {1'b0, OVERHEAD}) <= {1'b0, h_ff})) begin
               b_in = h_ff - OVERHEAD - rdata;
               m_in = rdata + size_ff + OVERHEAD;
               left_in = 1'b1;
            end
         end
         OP_F_LPH:   begin we = 1'b1; wbyte = b_ff;    wdata = m_ff; end
         OP_F_LF:    begin we = 1'b1; wbyte = foot_ff; wdata = m_ff; end
         OP_F_LPF:   begin we = 1'b1; wbyte = h_ff - FTR_BYTES; end
         OP_F_LH0:   begin we = 1'b1; wbyte = h_ff; end
         OP_F_LH4:   begin we = 1'b1; wbyte = h_ff + LINK_PREV; end
         OP_F_LH8:   begin we = 1'b1; wbyte = h_ff + LINK_NEXT; end
         // merge with right neighbor
         OP_R_RDNH: begin
            nh_in = foot_ff + FTR_BYTES;  wbyte = foot_ff + FTR_BYTES;
         end
         OP_R_CHK:   begin rest_in = rdata;  wbyte = b_ff; end
         OP_R_RDNP: begin
            m_in = rd_size + rest_ff + OVERHEAD;  wbyte = nh_ff + LINK_PREV;
         end
         OP_R_RDNN:  begin pv_in = rdata;  wbyte = nh_ff + LINK_NEXT; end
         OP_R_WB: begin
            nx_in = rdata;  we = 1'b1;  wbyte = b_ff;  wdata = m_ff;
         end
         OP_R_WNF:   begin we = 1'b1; wbyte = nh_ff + HDR_BYTES + rest_ff; wdata = m_ff; end
         OP_R_WF0:   begin we = 1'b1; wbyte = foot_ff; end
         OP_R_L1:    begin we = 1'b1; wbyte = pv_ff + LINK_NEXT; wdata = nx_ff; end
         OP_R_L2:    begin we = 1'b1; wbyte = nx_ff + LINK_PREV; wdata = pv_ff; end
         OP_R_S1:    begin we = 1'b1; wbyte = b_ff + LINK_PREV;  wdata = b_ff; end
         OP_R_S2:    begin we = 1'b1; wbyte = b_ff + LINK_NEXT;  wdata = b_ff; end
         OP_R_M1:    begin we = 1'b1; wbyte = b_ff + LINK_PREV;  wdata = pv_ff; end
         OP_R_M2:    begin we = 1'b1; wbyte = b_ff + LINK_NEXT;  wdata = nx_ff; end
         OP_R_M3:    begin we = 1'b1; wbyte = pv_ff + LINK_NEXT; wdata = b_ff; end
         OP_R_M4:    begin we = 1'b1; wbyte = nx_ff + LINK_PREV; wdata = b_ff; end
         OP_R_TAIL: begin
            if (head_ff == nh_ff) head_in = b_ff;
            we = 1'b1;  wbyte = nh_ff;  right_in = 1'b1;
         end
         OP_R_Z4:    begin we = 1'b1; wbyte = nh_ff + LINK_PREV; end
         OP_R_Z8:    begin we = 1'b1; wbyte = nh_ff + LINK_NEXT; end
         // lone block insert
         OP_N_E1:    begin we = 1'b1; wbyte = b_ff + LINK_PREV; wdata = b_ff; end
         OP_N_E2: begin
            we = 1'b1;  wbyte = b_ff + LINK_NEXT;  wdata = b_ff;
            head_in = b_ff;  empty_in = 1'b0;
         end
         OP_N_RDT:   begin wbyte = head_ff + LINK_PREV; end
         OP_N_T1: begin
            pv_in = rdata;  we = 1'b1;  wbyte = b_ff + LINK_PREV;  wdata = rdata;
         end
         OP_N_T2:    begin we = 1'b1; wbyte = b_ff + LINK_NEXT;    wdata = head_ff; end
         OP_N_T3:    begin we = 1'b1; wbyte = pv_ff + LINK_NEXT;   wdata = b_ff; end
         OP_N_T4:    begin we = 1'b1; wbyte = head_ff + LINK_PREV; wdata = b_ff; end
         // results
         OP_RES_GRANT: begin
            status_in = RSP_GRANTED;  gaddr_in = 16'(h_ff + HDR_BYTES);
         end
         OP_RES_NOFIT: begin status_in = RSP_NO_FIT;  gaddr_in = 16'd0; end
         OP_RES_FREED: begin status_in = RSP_FREED;   gaddr_in = 16'd0; end
         OP_RES_IGN:   begin status_in = RSP_IGNORED; gaddr_in = 16'd0; end
         default: ;
      endcase
   end

   // list state and clear pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 32'd0;
         empty_ff <= 1'b0;
         clr_ff   <= '0;
         left_ff  <= 1'b0;
         right_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         empty_ff <= empty_in;
         clr_ff   <= clr_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      need_ff <= need_in;  cur_ff <= cur_in;   h_ff <= h_in;       size_ff <= size_in;
      foot_ff <= foot_in;  nx_ff <= nx_in;     pv_ff <= pv_in;     nh_ff <= nh_in;
      rest_ff <= rest_in;  m_ff <= m_in;       hv_ff <= hv_in;     b_ff <= b_in;
      addr_ff <= addr_in;  kind_ff <= kind_in; walk_ff <= walk_in;
      status_ff <= status_in;  gaddr_ff <= gaddr_in;
   end

   assign rsp_status          = status_ff;
   assign rsp_granted_address = gaddr_ff;
endmodule

// ===== rtl/core/btffa_ctrl.sv =====
`timescale 1ns / 1ps

module btffa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  btffa_pkg::sts_type sts,
   output btffa_pkg::cmd_type cmd
);
   import btffa_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR, S_INIT_LO, S_INIT_HI, S_IDLE, S_DISPATCH,
      S_A_START, S_A_TEST, S_A_NEXT, S_A_CHK,
      S_S_FOOT, S_S_NH, S_S_RD, S_S_NHNX, S_S_NHPV, S_S_NXPV, S_S_HNX, S_S_NFOOT,
      S_U_RDNX, S_U_RDPV, S_U_HEAD, S_U_DEC, S_U_PVNX, S_U_NXPV, S_U_HPV, S_U_HNX,
      S_U_HDR, S_U_FTR,
      S_F_START, S_F_HDR, S_F_FTR, S_F_WH, S_F_WF, S_F_RDPF, S_F_LCHK,
      S_F_LPH, S_F_LF, S_F_LPF, S_F_LH0, S_F_LH4, S_F_LH8,
      S_R_START, S_R_RDNH, S_R_CHK, S_R_RDNP, S_R_RDNN, S_R_WB, S_R_WNF, S_R_WF0,
      S_R_L1, S_R_L2, S_R_S1, S_R_S2, S_R_M1, S_R_M2, S_R_M3, S_R_M4,
      S_R_TAIL, S_R_Z4, S_R_Z8,
      S_N_START, S_N_E1, S_N_E2, S_N_RDT, S_N_T1, S_N_T2, S_N_T3, S_N_T4,
      S_RES_GRANT, S_RES_NOFIT, S_RES_FREED, S_RES_IGN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_busy;
   logic      accept;
   logic      res_state;

   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign accept    = (state_ff == S_IDLE) && req_valid;
   assign res_state = (state_ff == S_RES_GRANT) || (state_ff == S_RES_NOFIT) ||
                      (state_ff == S_RES_FREED) || (state_ff == S_RES_IGN);

   // state to datapath operation
   always_comb begin
      cmd.load = accept;
      case (state_ff)
         S_CLEAR:     cmd.op = OP_CLEAR;
         S_INIT_LO:   cmd.op = OP_INIT_LO;
         S_INIT_HI:   cmd.op = OP_INIT_HI;
         S_A_START:   cmd.op = OP_A_START;
         S_A_TEST:    cmd.op = OP_A_TEST;
         S_A_NEXT:    cmd.op = OP_A_NEXT;
         S_A_CHK:     cmd.op = OP_A_CHK;
         S_S_FOOT:    cmd.op = OP_S_FOOT;
         S_S_NH:      cmd.op = OP_S_NH;
         S_S_RD:      cmd.op = OP_S_RD;
         S_S_NHNX:    cmd.op = OP_S_NHNX;
         S_S_NHPV:    cmd.op = OP_S_NHPV;
         S_S_NXPV:    cmd.op = OP_S_NXPV;
         S_S_HNX:     cmd.op = OP_S_HNX;
         S_S_NFOOT:   cmd.op = OP_S_NFOOT;
         S_U_RDNX:    cmd.op = OP_U_RDNX;
         S_U_RDPV:    cmd.op = OP_U_RDPV;
         S_U_HEAD:    cmd.op = OP_U_HEAD;
         S_U_PVNX:    cmd.op = OP_U_PVNX;
         S_U_NXPV:    cmd.op = OP_U_NXPV;
         S_U_HPV:     cmd.op = OP_U_HPV;
         S_U_HNX:     cmd.op = OP_U_HNX;
         S_U_HDR:     cmd.op = OP_U_HDR;
         S_U_FTR:     cmd.op = OP_U_FTR;
         S_F_START:   cmd.op = OP_F_START;
         S_F_HDR:     cmd.op = OP_F_HDR;
         S_F_WH:      cmd.op = OP_F_WH;
         S_F_WF:      cmd.op = OP_F_WF;
         S_F_RDPF:    cmd.op = OP_F_RDPF;
         S_F_LCHK:    cmd.op = OP_F_LCHK;
         S_F_LPH:     cmd.op = OP_F_LPH;
         S_F_LF:      cmd.op = OP_F_LF;
         S_F_LPF:     cmd.op = OP_F_LPF;
         S_F_LH0:     cmd.op = OP_F_LH0;
         S_F_LH4:     cmd.op = OP_F_LH4;
         S_F_LH8:     cmd.op = OP_F_LH8;
         S_R_RDNH:    cmd.op = OP_R_RDNH;
         S_R_CHK:     cmd.op = OP_R_CHK;
         S_R_RDNP:    cmd.op = OP_R_RDNP;
         S_R_RDNN:    cmd.op = OP_R_RDNN;
         S_R_WB:      cmd.op = OP_R_WB;
         S_R_WNF:     cmd.op = OP_R_WNF;
         S_R_WF0:     cmd.op = OP_R_WF0;
         S_R_L1:      cmd.op = OP_R_L1;
         S_R_L2:      cmd.op = OP_R_L2;
         S_R_S1:      cmd.op = OP_R_S1;
         S_R_S2:      cmd.op = OP_R_S2;
         S_R_M1:      cmd.op = OP_R_M1;
         S_R_M2:      cmd.op = OP_R_M2;
         S_R_M3:      cmd.op = OP_R_M3;
         S_R_M4:      cmd.op = OP_R_M4;
         S_R_TAIL:    cmd.op = OP_R_TAIL;
         S_R_Z4:      cmd.op = OP_R_Z4;
         S_R_Z8:      cmd.op = OP_R_Z8;
         S_N_E1:      cmd.op = OP_N_E1;
         S_N_E2:      cmd.op = OP_N_E2;
         S_N_RDT:     cmd.op = OP_N_RDT;
         S_N_T1:      cmd.op = OP_N_T1;
         S_N_T2:      cmd.op = OP_N_T2;
         S_N_T3:      cmd.op = OP_N_T3;
         S_N_T4:      cmd.op = OP_N_T4;
         S_RES_GRANT: cmd.op = out_busy ? OP_NOP : OP_RES_GRANT;
         S_RES_NOFIT: cmd.op = out_busy ? OP_NOP : OP_RES_NOFIT;
         S_RES_FREED: cmd.op = out_busy ? OP_NOP : OP_RES_FREED;
         S_RES_IGN:   cmd.op = out_busy ? OP_NOP : OP_RES_IGN;
         default:     cmd.op = OP_NOP;
      endcase
   end

   // sequencing
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_CLEAR:     if (sts.clr_last) state_in = S_INIT_LO;
         S_INIT_LO:   state_in = S_INIT_HI;
         S_INIT_HI:   state_in = S_IDLE;
         S_IDLE:      if (req_valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (sts.kind) state_in = sts.bad_addr ? S_RES_IGN : S_F_START;
            else          state_in = sts.empty ? S_RES_NOFIT : S_A_START;
         end
         S_A_START:   state_in = S_A_TEST;
         S_A_TEST:    state_in = sts.fit ? S_A_CHK : S_A_NEXT;
         S_A_NEXT:    state_in = (sts.next_is_head || sts.walk_last) ? S_RES_NOFIT : S_A_TEST;
         S_A_CHK:     state_in = sts.split ? S_S_FOOT : S_U_RDNX;
         S_S_FOOT:    state_in = S_S_NH;
         S_S_NH:      state_in = S_S_RD;
         S_S_RD:      state_in = S_S_NHNX;
         S_S_NHNX:    state_in = S_S_NHPV;
         S_S_NHPV:    state_in = S_S_NXPV;
         S_S_NXPV:    state_in = S_S_HNX;
         S_S_HNX:     state_in = S_S_NFOOT;
         S_S_NFOOT:   state_in = S_U_RDNX;
         S_U_RDNX:    state_in = S_U_RDPV;
         S_U_RDPV:    state_in = S_U_HEAD;
         S_U_HEAD:    state_in = S_U_DEC;
         S_U_DEC:     state_in = sts.empty ? S_U_HPV : S_U_PVNX;
         S_U_PVNX:    state_in = S_U_NXPV;
         S_U_NXPV:    state_in = S_U_HPV;
         S_U_HPV:     state_in = S_U_HNX;
         S_U_HNX:     state_in = S_U_HDR;
         S_U_HDR:     state_in = S_U_FTR;
         S_U_FTR:     state_in = S_RES_GRANT;
         S_F_START:   state_in = S_F_HDR;
         S_F_HDR:     state_in = (sts.no_mark || sts.bad_size) ? S_RES_IGN : S_F_FTR;
         S_F_FTR:     state_in = sts.foot_mismatch ? S_RES_IGN : S_F_WH;
         S_F_WH:      state_in = S_F_WF;
         S_F_WF:      state_in = sts.h_gt4 ? S_F_RDPF : S_R_START;
         S_F_RDPF:    state_in = S_F_LCHK;
         S_F_LCHK:    state_in = sts.left_ok ? S_F_LPH : S_R_START;
         S_F_LPH:     state_in = S_F_LF;
         S_F_LF:      state_in = S_F_LPF;
         S_F_LPF:     state_in = S_F_LH0;
         S_F_LH0:     state_in = S_F_LH4;
         S_F_LH4:     state_in = S_F_LH8;
         S_F_LH8:     state_in = S_R_START;
         S_R_START:   state_in = sts.right_room ? S_R_RDNH : S_N_START;
         S_R_RDNH:    state_in = S_R_CHK;
         S_R_CHK:     state_in = sts.right_ok ? S_R_RDNP : S_N_START;
         S_R_RDNP:    state_in = S_R_RDNN;
         S_R_RDNN:    state_in = S_R_WB;
         S_R_WB:      state_in = S_R_WNF;
         S_R_WNF:     state_in = S_R_WF0;
         S_R_WF0: begin
            if (sts.left)          state_in = S_R_L1;
            else if (sts.nn_is_nh) state_in = S_R_S1;
            else                   state_in = S_R_M1;
         end
         S_R_L1:      state_in = S_R_L2;
         S_R_L2:      state_in = S_R_TAIL;
         S_R_S1:      state_in = S_R_S2;
         S_R_S2:      state_in = S_R_TAIL;
         S_R_M1:      state_in = S_R_M2;
         S_R_M2:      state_in = S_R_M3;
         S_R_M3:      state_in = S_R_M4;
         S_R_M4:      state_in = S_R_TAIL;
         S_R_TAIL:    state_in = S_R_Z4;
         S_R_Z4:      state_in = S_R_Z8;
         S_R_Z8:      state_in = S_N_START;
         S_N_START: begin
            if (sts.left || sts.right) state_in = S_RES_FREED;
            else if (sts.empty)        state_in = S_N_E1;
            else                       state_in = S_N_RDT;
         end
         S_N_E1:      state_in = S_N_E2;
         S_N_E2:      state_in = S_RES_FREED;
         S_N_RDT:     state_in = S_N_T1;
         S_N_T1:      state_in = S_N_T2;
         S_N_T2:      state_in = S_N_T3;
         S_N_T3:      state_in = S_N_T4;
         S_N_T4:      state_in = S_RES_FREED;
         S_RES_GRANT, S_RES_NOFIT, S_RES_FREED, S_RES_IGN: begin
            if (!out_busy) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default:     state_in = S_IDLE;
      endcase
      if (!res_state && !out_busy) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== rtl/core/boundary_tag_first_fit_allocator.sv =====
`timescale 1ns / 1ps

// Boundary-tag first-fit allocator over a 64 KiB pool held in a single-port
// 16384 x 32 RAM. After reset the block clears the whole pool, one word per
// cycle, then writes the initial free block; req_stall stays high meanwhile.
// Every transaction then runs as a sequence of RAM accesses, one per cycle
// except while a result step is held by a stalled output, so the single
// RAM port sets the time per item. An allocate walks the free list for the
// first block that fits and splits the found block when the remainder is
// large enough; a no-fit answer comes at once on an empty list, else after
// the walk. A free is rejected after validation, or accepted and merged with
// whichever neighbors are free. One result per request; a finished result
// waits in the output register while the next request is taken, and the
// last step of a request holds while that register is still stalled.
module boundary_tag_first_fit_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [16:0] req_request_size,
   input  logic [15:0] req_block_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_granted_address
);
   import btffa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   btffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // pool memory and working registers
   btffa_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_kind            (req_kind),
      .req_request_size    (req_request_size),
      .req_block_address   (req_block_address),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address)
   );
endmodule
